[rtl/xsr_pkg.sv]
package xsr_pkg;

    // LCG seed scrambler and xorshift mixing constants
    localparam logic [31:0] LCG_MUL = 32'h7AFB_2C23;
    localparam logic [31:0] LCG_ADD = 32'h0008_94C3;
    localparam logic [31:0] MIX_3   = 32'h4B2A_A8D3;
    localparam int unsigned SH_A = 11;
    localparam int unsigned SH_B = 8;
    localparam int unsigned SH_C = 19;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned CNT_W  = $clog2(WORD_W);

    // job queue between front and back
    localparam int unsigned QDEPTH = 2;
    localparam int unsigned QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

    // item kinds
    localparam logic [1:0] KIND_RESEED = 2'd0;
    localparam logic [1:0] KIND_RAW    = 2'd1;
    localparam logic [1:0] KIND_RANGED = 2'd2;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    // one draw handed from front to back
    typedef struct packed {
        logic [31:0] raw;
        logic [31:0] low;
        logic [31:0] span;
        logic        ranged;
    } t_job;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_DONE
    } t_state;

    // one xorshift128 step on the words built from the seed
    function automatic logic [31:0] xs_word(input logic [31:0] s);
        logic [31:0] t;
        t = s ^ MIX_3;
        t = t ^ (t << SH_A);
        t = t ^ (t >> SH_B);
        return t ^ s ^ (s >> SH_C);
    endfunction

endpackage

[rtl/xsr_front.sv]
module xsr_front
    import xsr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic [1:0]  i_kind,
    input  logic [31:0] i_seed_value,
    input  logic [31:0] i_range_low,
    input  logic [31:0] i_range_high,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_data,
    output logic        o_job_push,
    output t_job        o_job
);

    logic [31:0] r_seed, n_seed;
    logic [31:0] r_fallback;
    logic [31:0] seed_eff;
    logic [31:0] lcg_src;
    logic        seed_we;

    // zero seed falls back to the configured value
    assign seed_eff = (r_seed == '0) ? r_fallback : r_seed;

    // classify the item
    always_comb begin
        seed_we    = 1'b0;
        lcg_src    = seed_eff;
        o_job_push = 1'b0;
        unique case (i_kind) inside
            KIND_RESEED: begin
                seed_we = i_accept;
                lcg_src = i_seed_value;
            end
            KIND_RAW, KIND_RANGED: begin
                seed_we    = i_accept;
                o_job_push = i_accept;
            end
            KIND_UNUSED: begin
                seed_we = 1'b0;
            end
            default: begin
                seed_we = 1'b0;
            end
        endcase
    end

    // LCG successor, low word only
    assign n_seed = 32'(lcg_src * LCG_MUL + LCG_ADD);

    // job payload
    assign o_job.raw    = xs_word(seed_eff);
    assign o_job.low    = i_range_low;
    assign o_job.span   = 32'(i_range_high - i_range_low);
    assign o_job.ranged = (i_kind == KIND_RANGED);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed     <= '0;
            r_fallback <= 32'd1;
        end else begin
            if (seed_we) begin
                r_seed <= n_seed;
            end
            if (i_cfg_we) begin
                r_fallback <= i_cfg_data;
            end
        end
    end

endmodule

[rtl/xsr_fifo.sv]
module xsr_fifo
    import xsr_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr,
    input  t_job i_wr_data,
    input  logic i_rd,
    output t_job o_rd_data,
    output logic o_full,
    output logic o_empty
);

    t_job              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              wr_en, rd_en;

    assign o_full    = (r_count == QCNT_W'(QDEPTH));
    assign o_empty   = (r_count == '0);
    assign wr_en     = i_wr && !o_full;
    assign rd_en     = i_rd && !o_empty;
    assign o_rd_data = r_mem[r_rd_ptr];

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QDEPTH - 1)) ? '0 : QPTR_W'(p + 1'b1);
    endfunction

    // storage
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (rd_en) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (wr_en && !rd_en) begin
                r_count <= QCNT_W'(r_count + 1'b1);
            end else if (rd_en && !wr_en) begin
                r_count <= QCNT_W'(r_count - 1'b1);
            end
        end
    end

`ifndef SYNTH
    // fill level never passes the depth
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QDEPTH))
        else $error("job queue overfilled");
`endif

endmodule

[rtl/xsr_back.sv]
module xsr_back
    import xsr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_job_empty,
    input  t_job        i_job,
    output logic        o_job_pop,
    input  logic        i_pop,
    output logic        o_empty,
    output logic [31:0] o_raw_value,
    output logic [31:0] o_ranged_value,
    output logic        o_range_error
);

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [WORD_W:0]    r_rem, n_rem;
    logic [WORD_W-1:0]  r_quo, n_quo;
    logic [31:0]        r_span, r_low, r_raw;
    logic               r_ranged, r_err;
    logic               load;
    logic [WORD_W:0]    shifted;
    logic [WORD_W:0]    diff;
    logic               last;

    assign load    = (r_state == ST_IDLE) && !i_job_empty;
    assign last    = (r_cnt == CNT_W'(WORD_W - 1));
    assign shifted = {r_rem[WORD_W-1:0], r_quo[WORD_W-1]};
    assign diff    = shifted - {1'b0, r_span};

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (!i_job_empty) begin
                    n_state = (i_job.ranged && (i_job.span != '0)) ? ST_CALC : ST_DONE;
                end
            end
            ST_CALC: begin
                if (last) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_pop) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // restoring remainder, one bit a cycle
    always_comb begin
        n_rem = r_rem;
        n_quo = r_quo;
        n_cnt = r_cnt;
        if (load) begin
            n_rem = '0;
            n_quo = i_job.raw;
            n_cnt = '0;
        end else if (r_state == ST_CALC) begin
            n_rem = diff[WORD_W] ? shifted : diff;
            n_quo = {r_quo[WORD_W-2:0], 1'b0};
            n_cnt = CNT_W'(r_cnt + 1'b1);
        end
    end

    // outputs
    always_comb begin
        o_job_pop      = load;
        o_empty        = (r_state != ST_DONE);
        o_raw_value    = r_raw;
        o_range_error  = r_err;
        o_ranged_value = (r_ranged && !r_err) ? 32'(r_rem[WORD_W-1:0] + r_low) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_cnt <= n_cnt;
        if (load) begin
            r_span   <= i_job.span;
            r_low    <= i_job.low;
            r_raw    <= i_job.raw;
            r_ranged <= i_job.ranged;
            r_err    <= i_job.ranged && (i_job.span == '0);
        end
    end

`ifndef SYNTH
    // partial remainder stays below the divisor
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CALC) |-> (r_rem < {1'b0, r_span}))
        else $error("remainder out of range");

    // last division step hands over the result
    a_calc_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CALC && last) |=> (r_state == ST_DONE))
        else $error("divider did not finish");

    // error result carries a zero ranged value
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && o_range_error) |-> (o_ranged_value == '0))
        else $error("ranged value nonzero on error");
`endif

endmodule

[rtl/xorshift128_lcg_reseed_rng_core.sv]
// Xorshift128 random source with an LCG-scrambled 32-bit seed. Input items
// are taken through push/full and results leave through empty/pop. A reseed
// updates the seed and gives no result; kind 3 is dropped. Draws are taken
// one a cycle into a two-entry job queue while it has room. Each job then
// occupies the back end: a raw draw has its result on the ports in the cycle
// after it is taken from the queue head, a ranged draw once the restoring
// remainder unit that retires one dividend bit per cycle is through (at once,
// with the range error set, for a zero span). The back end takes the next job
// in the cycle after the current result is popped. The fallback seed is
// written through the cfg valid/ready channel, which is always ready.
module xorshift128_lcg_reseed_rng_core
    import xsr_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic [1:0]         i_kind,
    input  logic [31:0]        i_seed_value,
    input  logic signed [31:0] i_range_low,
    input  logic signed [31:0] i_range_high,
    output logic               empty,
    input  logic               pop,
    output logic [31:0]        o_raw_value,
    output logic signed [31:0] o_ranged_value,
    output logic               o_range_error,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [31:0]        i_cfg_data
);

    logic        accept;
    logic        job_push;
    t_job        job_in, job_out;
    logic        job_full, job_empty, job_pop;
    logic [31:0] ranged_u;

    assign accept      = push && !full;
    assign full        = job_full;
    assign o_cfg_ready = 1'b1;

    xsr_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_kind       (i_kind),
        .i_seed_value (i_seed_value),
        .i_range_low  (i_range_low),
        .i_range_high (i_range_high),
        .i_cfg_we     (i_cfg_valid),
        .i_cfg_data   (i_cfg_data),
        .o_job_push   (job_push),
        .o_job        (job_in)
    );

    xsr_fifo u_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (job_push),
        .i_wr_data (job_in),
        .i_rd      (job_pop),
        .o_rd_data (job_out),
        .o_full    (job_full),
        .o_empty   (job_empty)
    );

    xsr_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_job_empty    (job_empty),
        .i_job          (job_out),
        .o_job_pop      (job_pop),
        .i_pop          (pop),
        .o_empty        (empty),
        .o_raw_value    (o_raw_value),
        .o_ranged_value (ranged_u),
        .o_range_error  (o_range_error)
    );

    assign o_ranged_value = $signed(ranged_u);

endmodule
